>>> rtl/core/itp_pkg.sv
package itp_pkg;

    // Table and counter sizes.
    localparam int PC_TABLE_DEPTH = 1024;
    localparam int COUNT_WIDTH    = 48;
    localparam int PC_WIDTH       = 64;
    localparam int ADDR_W         = (PC_TABLE_DEPTH > 1) ? $clog2(PC_TABLE_DEPTH) : 1;
    localparam int FILL_W         = $clog2(PC_TABLE_DEPTH + 1);

    // Operation class codes.
    localparam int CLASS_W     = 3;
    localparam int NUM_CLASSES = 5;
    localparam logic [CLASS_W-1:0] CLS_ALU    = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_LOAD   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_STORE  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_BRANCH = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_MISC   = 3'd4;

    // Result beat layout.
    localparam int OUT_FIELDS_W = 7 * COUNT_WIDTH + FILL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 3;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // Response of the address search back to the top level.
    typedef struct packed {
        logic done;
        logic is_new;
        logic overflow;
    } t_search_rsp;

    // Modeled cycle cost of one valid instruction.
    function automatic logic [1:0] cycle_cost(input logic [CLASS_W-1:0] cls);
        logic [1:0] cost;
        unique case (cls)
            CLS_BRANCH: cost = 2'd3;
            CLS_LOAD,
            CLS_STORE:  cost = 2'd2;
            default:    cost = 2'd1;
        endcase
        return cost;
    endfunction

    // Saturating add of a small increment to a counter.
    function automatic t_count sat_add(input t_count a, input logic [1:0] k);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, a} + {{(COUNT_WIDTH - 1){1'b0}}, k};
        return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/core/instruction_trace_profiler_unit.sv
// Instruction trace profiler: each input beat is one retired instruction (class in tuser,
// address in tdata) and yields one output beat with all running counts and three flags.
// An item whose address is new runs a linear search over all stored distinct addresses,
// reading and comparing one table entry per cycle; a repeated address ends the search at
// its match, and an invalid class skips the search. The 1024-entry address table has no
// reset pass: a fill count marks which entries are live. The next beat is taken while a
// finished result waits.
module instruction_trace_profiler_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pc [63:0]
    input  logic [itp_pkg::PC_WIDTH-1:0]         s_axis_tdata,
    // op_class [2:0]
    input  logic [itp_pkg::CLASS_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // inst_total [47:0], cycle_total [95:48], distinct_pc_total [106:96],
    // alu_total [154:107], load_total [202:155], store_total [250:203],
    // branch_total [298:251], misc_total [346:299], zero pad [351:347]
    output logic [itp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // new_pc [0], table_overflow [1], bad_class [2]
    output logic [itp_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                        r_state;
    itp_pkg::t_count                   r_inst;
    itp_pkg::t_count                   r_cycle;
    itp_pkg::t_count                   r_cls_cnt [itp_pkg::NUM_CLASSES];
    logic                              r_new;
    logic                              r_ovf;
    logic                              r_bad;
    logic                              r_m_tvalid;
    logic [itp_pkg::OUT_TDATA_W-1:0]   r_m_tdata;
    logic [itp_pkg::OUT_TUSER_W-1:0]   r_m_tuser;

    logic                              in_beat;
    logic                              cls_ok;
    logic                              start;
    logic                              load_out;
    itp_pkg::t_search_rsp              rsp;
    logic [itp_pkg::FILL_W-1:0]        fill;

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        in_beat       = s_axis_tvalid && s_axis_tready;
        cls_ok        = (s_axis_tuser <= itp_pkg::CLS_MISC);
        start         = in_beat && cls_ok;
        load_out      = (r_state == ST_DONE) && (!r_m_tvalid || m_axis_tready);
    end

    itp_pc_table u_pc_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_pc    (s_axis_tdata),
        .o_rsp   (rsp),
        .o_fill  (fill)
    );

    // Item sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_state <= cls_ok ? ST_WAIT : ST_DONE;
                    end
                end
                ST_WAIT: begin
                    if (rsp.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Per-item flags.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_bad <= !cls_ok;
            r_new <= 1'b0;
            r_ovf <= 1'b0;
        end else if ((r_state == ST_WAIT) && rsp.done) begin
            r_new <= rsp.is_new;
            r_ovf <= rsp.overflow;
        end
    end

    // Saturating counters, updated when a valid instruction is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inst  <= '0;
            r_cycle <= '0;
            for (int c = 0; c < itp_pkg::NUM_CLASSES; c++) begin
                r_cls_cnt[c] <= '0;
            end
        end else if (start) begin
            r_inst  <= itp_pkg::sat_add(r_inst, 2'd1);
            r_cycle <= itp_pkg::sat_add(r_cycle, itp_pkg::cycle_cost(s_axis_tuser));
            for (int c = 0; c < itp_pkg::NUM_CLASSES; c++) begin
                if (s_axis_tuser == itp_pkg::CLASS_W'(c)) begin
                    r_cls_cnt[c] <= itp_pkg::sat_add(r_cls_cnt[c], 2'd1);
                end
            end
        end
    end

    // Output register: holds a finished beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (load_out) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_tdata <= {{(itp_pkg::OUT_TDATA_W - itp_pkg::OUT_FIELDS_W){1'b0}},
                          r_cls_cnt[4], r_cls_cnt[3], r_cls_cnt[2], r_cls_cnt[1],
                          r_cls_cnt[0], fill, r_cycle, r_inst};
            r_m_tuser <= {r_bad, r_ovf, r_new};
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // A search ends either stored or overflowed or found, never both flags.
    a_rsp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> !(rsp.is_new && rsp.overflow))
        else $error("search reported both new address and overflow");

    // An appended address grows the fill count by exactly one.
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.is_new |=> (fill == $past(fill) + 1'b1))
        else $error("fill count did not advance on append");

    // The fill count never passes the table depth.
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= itp_pkg::FILL_W'(itp_pkg::PC_TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // A rejected class leaves the instruction and cycle counts and the fill count untouched.
    a_bad_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !cls_ok) |=> ($stable(r_inst) && $stable(r_cycle) && $stable(fill)))
        else $error("invalid class changed a counter");

endmodule

>>> rtl/core/itp_pc_table.sv
module itp_pc_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [itp_pkg::PC_WIDTH-1:0]       i_pc,
    output itp_pkg::t_search_rsp               o_rsp,
    output logic [itp_pkg::FILL_W-1:0]         o_fill
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic [itp_pkg::PC_WIDTH-1:0] r_mem [itp_pkg::PC_TABLE_DEPTH];

    logic                         r_state;
    logic [itp_pkg::FILL_W-1:0]   r_fill;
    logic [itp_pkg::FILL_W-1:0]   r_addr;
    logic [itp_pkg::PC_WIDTH-1:0] r_pc;
    logic [itp_pkg::PC_WIDTH-1:0] r_rd_data;
    logic                         r_rd_vld;

    logic issue;
    logic match;
    logic last;
    logic hit;
    logic miss;
    logic full;

    // Shared compare: one stored address against the searched one per cycle.
    always_comb begin
        issue = (r_state == ST_SEARCH) && (r_addr < r_fill);
        match = r_rd_vld && (r_rd_data == r_pc);
        last  = (r_addr == r_fill);
        hit   = (r_state == ST_SEARCH) && match;
        miss  = (r_state == ST_SEARCH) && last && !match;
        full  = (r_fill == itp_pkg::FILL_W'(itp_pkg::PC_TABLE_DEPTH));
    end

    // Sequencer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_SEARCH;
                        r_addr  <= '0;
                    end
                end
                ST_SEARCH: begin
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (hit || miss) begin
                        r_state <= ST_IDLE;
                    end
                    if (miss && !full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Searched address is held for the whole pass.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start) begin
            r_pc <= i_pc;
        end
    end

    // Address table: one read and one append port.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_addr[itp_pkg::ADDR_W-1:0]];
        end
        if (miss && !full) begin
            r_mem[r_fill[itp_pkg::ADDR_W-1:0]] <= r_pc;
        end
    end

    always_comb begin
        o_rsp.done     = hit || miss;
        o_rsp.is_new   = miss && !full;
        o_rsp.overflow = miss && full;
        o_fill         = r_fill;
    end

endmodule
